[rtl/core/odid_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the overlapping dword index decryptor.
package odid_pkg;

   // Hard key pairs, used alternately on successive dwords
   localparam logic [31:0] FIRST_KEY  = 32'hE1DA85E3;
   localparam int          FIRST_ROT  = 3;
   localparam logic [31:0] SECOND_KEY = 32'h627E907B;
   localparam int          SECOND_ROT = 7;

   // Job queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   // Window fill levels
   localparam logic [1:0] COUNT_FULL = 2'd3;

   // One job: up to four result bytes, oldest in bits 7:0
   typedef struct packed {
      logic [31:0] data;
      logic [1:0]  final_idx;   // index of the job's last byte
      logic        last;        // job closes the index
   } job_type;

   typedef struct packed {
      logic full;
      logic not_empty;
   } queue_status_type;

endpackage

[rtl/core/odid_queue.sv]
`timescale 1ns / 1ps
// Short job queue between the decrypting front and the emitting back.
module odid_queue
   import odid_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  job_type          push_job,
   input  logic             pop,
   output job_type          head_job,
   output queue_status_type status
);

   job_type                  entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0]   count_ff, count_in;
   logic                     do_push, do_pop;

   assign status.full      = (count_ff == QUEUE_CNT_W'(QUEUE_DEPTH));
   assign status.not_empty = (count_ff != '0);
   assign do_push          = push && !status.full;
   assign do_pop           = pop && status.not_empty;
   assign head_job         = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

[rtl/core/odid_front.sv]
`timescale 1ns / 1ps
// Front: takes bytes, keeps the window, decrypts dwords and builds jobs.
module odid_front
   import odid_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_write_enable,
   input  logic [31:0]      csr_write_data,
   input  logic             req_valid,
   output logic             req_stall,
   input  logic [7:0]       req_data_byte,
   input  logic             req_is_last,
   input  queue_status_type q_status,
   output logic             push,
   output job_type          push_job
);

   function automatic logic [31:0] rotr(input logic [31:0] v, input int r);
      rotr = (v >> r) | (v << (32 - r));
   endfunction

   logic [31:0] index_key_ff;
   logic [23:0] window_ff, window_in;
   logic [1:0]  count_ff, count_in;
   logic        ksel_ff, ksel_in;

   logic        accept;
   logic [31:0] dword, diff, plain;
   logic [23:0] fill_window;

   assign req_stall = q_status.full;
   assign accept    = req_valid && !req_stall;
   assign dword     = {req_data_byte, window_ff};

   always_comb begin
      if (ksel_ff) begin
         diff  = dword - SECOND_KEY;
         plain = index_key_ff ^ rotr(diff, SECOND_ROT);
      end else begin
         diff  = dword - FIRST_KEY;
         plain = index_key_ff ^ rotr(diff, FIRST_ROT);
      end
   end

   // pending bytes sit above zeros, so the new byte lands at the fill level
   always_comb begin
      case (count_ff)
         2'd0:    fill_window = {16'h0000, req_data_byte};
         2'd1:    fill_window = {8'h00, req_data_byte, window_ff[7:0]};
         2'd2:    fill_window = {req_data_byte, window_ff[15:0]};
         default: fill_window = window_ff;
      endcase
   end

   always_comb begin
      window_in = window_ff;
      count_in  = count_ff;
      ksel_in   = ksel_ff;
      push      = 1'b0;
      push_job  = '{data: plain, final_idx: 2'd0, last: 1'b0};
      if (accept) begin
         if (count_ff != COUNT_FULL) begin
            window_in = fill_window;
            count_in  = count_ff + 1'b1;
            if (req_is_last) begin
               push     = 1'b1;
               push_job = '{data: {8'h00, fill_window}, final_idx: count_ff, last: 1'b1};
            end
         end else begin
            window_in = plain[31:8];
            ksel_in   = !ksel_ff;
            push      = 1'b1;
            push_job  = '{data: plain, final_idx: req_is_last ? 2'd3 : 2'd0,
                          last: req_is_last};
         end
         if (req_is_last) begin
            window_in = '0;
            count_in  = '0;
            ksel_in   = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         index_key_ff <= '0;
         window_ff    <= '0;
         count_ff     <= '0;
         ksel_ff      <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            index_key_ff <= csr_write_data;
         end
         window_ff <= window_in;
         count_ff  <= count_in;
         ksel_ff   <= ksel_in;
      end
   end

endmodule

[rtl/core/odid_back.sv]
`timescale 1ns / 1ps
// Back: holds one job and hands its bytes out one item a cycle while rsp is not stalled.
module odid_back
   import odid_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  queue_status_type q_status,
   input  job_type          head_job,
   output logic             pop,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic [7:0]       rsp_out_byte,
   output logic             rsp_out_last
);

   logic        cur_valid_ff, cur_valid_in;
   job_type     cur_job_ff;
   logic [1:0]  idx_ff, idx_in;
   logic        at_end, taken;

   assign at_end       = (idx_ff == cur_job_ff.final_idx);
   assign taken        = cur_valid_ff && !rsp_stall;
   assign rsp_valid    = cur_valid_ff;
   assign rsp_out_byte = cur_job_ff.data[8*idx_ff +: 8];
   assign rsp_out_last = cur_job_ff.last && at_end;
   assign pop          = q_status.not_empty && (!cur_valid_ff || (taken && at_end));

   always_comb begin
      cur_valid_in = cur_valid_ff;
      idx_in       = idx_ff;
      if (pop) begin
         cur_valid_in = 1'b1;
         idx_in       = '0;
      end else if (taken) begin
         if (at_end) begin
            cur_valid_in = 1'b0;
         end else begin
            idx_in = idx_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         idx_ff       <= '0;
      end else begin
         cur_valid_ff <= cur_valid_in;
         idx_ff       <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         cur_job_ff <= head_job;
      end
   end

endmodule

[rtl/core/overlapping_dword_index_decrypt.sv]
`timescale 1ns / 1ps
// A byte that completes a dword is written into the queue, then into the back's job register, which drives rsp.
// Throughput: one byte a cycle while req_stall is low; only a closing byte costs extra, up to 4 items from one job.
// The rate is set by the back end, which hands out one item a cycle from its job register while rsp is not stalled.
// Reset (synchronous, active high) clears index_key, the window, the key select and the queue.
// Top level of the overlapping dword index decryptor.
module overlapping_dword_index_decrypt
   import odid_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write_enable,
   input  logic [31:0] csr_write_data,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_is_last,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_out_last
);

   // Front decrypts at once and writes a job per dword (or per short-stream flush);
   // filling bytes make no job. A closing job carries the three window bytes too.
   queue_status_type q_status;
   job_type          push_job;
   job_type          head_job;
   logic             push;
   logic             pop;

   odid_front u_front (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data_byte    (req_data_byte),
      .req_is_last      (req_is_last),
      .q_status         (q_status),
      .push             (push),
      .push_job         (push_job)
   );

   // Two-entry queue: the front keeps taking items while a result waits on rsp
   odid_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .head_job (head_job),
      .status   (q_status)
   );

   // Back walks the job's bytes, one item per accepted rsp cycle
   odid_back u_back (
      .clock        (clock),
      .reset        (reset),
      .q_status     (q_status),
      .head_job     (head_job),
      .pop          (pop),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_out_byte (rsp_out_byte),
      .rsp_out_last (rsp_out_last)
   );

endmodule

[rtl/core/odid_checker.sv]
`timescale 1ns / 1ps
// Port-level checks for the index decryptor, bound to the top level.
module odid_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_stall,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [7:0] rsp_out_byte,
   input logic       rsp_out_last
);

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_out_byte) && $stable(rsp_out_last))
      else $error("stalled rsp item changed");

   // reset empties both sides
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("block not idle after reset");

   // queue can only fill while the back end holds an item
   a_stall_needs_rsp: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid)
      else $error("req stalled with no rsp item pending");

endmodule

bind overlapping_dword_index_decrypt odid_checker u_odid_checker (
   .clock        (clock),
   .reset        (reset),
   .req_stall    (req_stall),
   .rsp_valid    (rsp_valid),
   .rsp_stall    (rsp_stall),
   .rsp_out_byte (rsp_out_byte),
   .rsp_out_last (rsp_out_last)
);
